>>> rtl/tccs_pkg.sv
// Shared types and constants of the text console with cursor and scroll.
package tccs_pkg;

    // Operation codes carried in the input tuser
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Control characters and the blank cell
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] RESET_ATTR   = 8'h07;

    // Configuration register indexes
    localparam logic REG_FOREGROUND = 1'b0;
    localparam logic REG_BACKGROUND = 1'b1;

    // Reset values of the colour registers
    localparam logic [3:0] FOREGROUND_RST = 4'd7;
    localparam logic [3:0] BACKGROUND_RST = 4'd0;

    // One command as taken from the input stream
    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } t_cmd;

    // One result as handed to the output register
    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic [7:0] read_attr;
        logic [7:0] read_char;
    } t_res;

endpackage

>>> rtl/tccs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/tccs_seq.sv
// Sequencer: cursor state, per-command store access, scroll/clear sweeps.
module tccs_seq
    import tccs_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_valid,
    input  t_cmd                           i_cmd,
    input  logic [7:0]                     i_attr,
    output logic                           o_ready,
    output logic                           o_res_valid,
    output t_res                           o_res,
    input  logic                           i_res_taken,
    output logic                           o_ram_we,
    output logic [$clog2(COLS*ROWS)-1:0]   o_ram_waddr,
    output logic [15:0]                    o_ram_wdata,
    output logic                           o_ram_re,
    output logic [$clog2(COLS*ROWS)-1:0]   o_ram_raddr,
    input  logic [15:0]                    i_ram_rdata
);

    localparam int CELLS = COLS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS + 1);

    localparam logic [31:0] CELLS_W = 32'(CELLS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_SCROLL = 3'd2;
    localparam logic [2:0] ST_CLEAR  = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]    r_state, n_state;
    logic          r_init,  n_init;
    logic [RW-1:0] r_row,   n_row;
    logic [CW-1:0] r_col,   n_col;
    logic [AW-1:0] r_w,     n_w;
    logic          r_pend,  n_pend;
    logic [7:0]    r_ch,    n_ch;
    logic          r_rdok,  n_rdok;
    logic [7:0]    r_rc,    n_rc;
    logic [7:0]    r_ra,    n_ra;

    logic [AW-1:0]    base_addr;
    logic [AW-1:0]    cur_addr;
    logic [AW+10:0]   idx_ext;
    logic [AW-1:0]    idx_addr;
    logic             idx_ok;
    logic             last_row;
    logic             wrap_pend;
    logic [15:0]      blank;
    logic [RW+4:0]    row_ext;
    logic [CW+6:0]    col_ext;

    // Cursor address and read address decoding
    assign base_addr = AW'(r_row) * AW'(COLS);
    assign cur_addr  = base_addr + AW'(r_col);
    assign idx_ext   = {{AW{1'b0}}, i_cmd.cell_index};
    assign idx_addr  = idx_ext[AW-1:0];
    assign idx_ok    = {21'd0, i_cmd.cell_index} < CELLS_W;
    assign last_row  = (r_row == RW'(ROWS - 1));
    assign wrap_pend = (r_col == CW'(COLS));
    assign blank     = {i_attr, CH_SPACE};

    // Next-state logic
    always_comb begin
        n_state     = r_state;
        n_init      = r_init;
        n_row       = r_row;
        n_col       = r_col;
        n_w         = r_w;
        n_pend      = r_pend;
        n_ch        = r_ch;
        n_rdok      = r_rdok;
        n_rc        = r_rc;
        n_ra        = r_ra;
        o_ram_we    = 1'b0;
        o_ram_waddr = cur_addr;
        o_ram_wdata = blank;
        o_ram_re    = 1'b0;
        o_ram_raddr = idx_addr;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_rc    = 8'd0;
                    n_ra    = 8'd0;
                    n_state = ST_DONE;
                    unique case (i_cmd.opcode)
                        OP_PUT: begin
                            if (i_cmd.char_code == CH_NEWLINE) begin
                                n_col = '0;
                                if (!last_row) begin
                                    n_row = r_row + RW'(1);
                                end else begin
                                    // prefetch the first source cell of the scroll
                                    n_w         = '0;
                                    n_pend      = 1'b0;
                                    o_ram_re    = 1'b1;
                                    o_ram_raddr = AW'(COLS);
                                    n_state     = ST_SCROLL;
                                end
                            end else if (i_cmd.char_code == CH_BACKSPACE) begin
                                // at home nothing happens
                                if (r_col != '0 || r_row != '0) begin
                                    o_ram_we    = 1'b1;
                                    o_ram_waddr = cur_addr - AW'(1);
                                    if (r_col != '0) begin
                                        n_col = r_col - CW'(1);
                                    end else begin
                                        n_col = CW'(COLS - 1);
                                        n_row = r_row - RW'(1);
                                    end
                                end
                            end else begin
                                o_ram_wdata = {i_attr, i_cmd.char_code};
                                if (wrap_pend && last_row) begin
                                    // scroll first, the character lands during the sweep
                                    n_col       = CW'(1);
                                    n_pend      = 1'b1;
                                    n_ch        = i_cmd.char_code;
                                    n_w         = '0;
                                    o_ram_re    = 1'b1;
                                    o_ram_raddr = AW'(COLS);
                                    n_state     = ST_SCROLL;
                                end else if (wrap_pend) begin
                                    // start of next row is base + COLS = cur_addr
                                    o_ram_we = 1'b1;
                                    n_row    = r_row + RW'(1);
                                    n_col    = CW'(1);
                                end else begin
                                    o_ram_we = 1'b1;
                                    n_col    = r_col + CW'(1);
                                end
                            end
                        end
                        OP_CLEAR: begin
                            n_w     = '0;
                            n_row   = '0;
                            n_col   = '0;
                            n_state = ST_CLEAR;
                        end
                        OP_READ: begin
                            o_ram_re = idx_ok;
                            n_rdok   = idx_ok;
                            n_state  = ST_READ;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end

            ST_READ: begin
                n_rc    = r_rdok ? i_ram_rdata[7:0]  : 8'd0;
                n_ra    = r_rdok ? i_ram_rdata[15:8] : 8'd0;
                n_state = ST_DONE;
            end

            ST_SCROLL: begin
                // copy cell w+COLS to w, then blank the bottom row (a pending character goes into its first cell)
                o_ram_we    = 1'b1;
                o_ram_waddr = r_w;
                if (r_w < AW'(CELLS - COLS)) begin
                    o_ram_wdata = i_ram_rdata;
                end else if (r_pend && r_w == AW'(CELLS - COLS)) begin
                    o_ram_wdata = {i_attr, r_ch};
                end else begin
                    o_ram_wdata = blank;
                end
                o_ram_re    = (r_w < AW'(CELLS - COLS - 1));
                o_ram_raddr = r_w + AW'(COLS + 1);
                if (r_w == AW'(CELLS - 1)) begin
                    n_w     = '0;
                    n_state = ST_DONE;
                end else begin
                    n_w = r_w + AW'(1);
                end
            end

            ST_CLEAR: begin
                // after reset the pass writes the reset cell instead
                o_ram_we    = 1'b1;
                o_ram_waddr = r_w;
                o_ram_wdata = r_init ? {RESET_ATTR, CH_SPACE} : blank;
                if (r_w == AW'(CELLS - 1)) begin
                    n_w     = '0;
                    n_init  = 1'b0;
                    n_state = r_init ? ST_IDLE : ST_DONE;
                end else begin
                    n_w = r_w + AW'(1);
                end
            end

            ST_DONE: begin
                if (i_res_taken) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_init  <= 1'b1;
            r_row   <= '0;
            r_col   <= '0;
            r_w     <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_row   <= n_row;
            r_col   <= n_col;
            r_w     <= n_w;
            r_pend  <= n_pend;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ch   <= n_ch;
        r_rdok <= n_rdok;
        r_rc   <= n_rc;
        r_ra   <= n_ra;
    end

    // Result, cursor fields cut to their port widths
    assign row_ext = {5'd0, r_row};
    assign col_ext = {7'd0, r_col};

    assign o_ready               = (r_state == ST_IDLE);
    assign o_res_valid           = (r_state == ST_DONE);
    assign o_res.read_char       = r_rc;
    assign o_res.read_attr       = r_ra;
    assign o_res.cursor_row      = row_ext[4:0];
    assign o_res.cursor_col      = col_ext[6:0];

endmodule

>>> rtl/text_console_cursor_scroll_top.sv
// Top level of the text console: stream ports, colour registers, output register.
//
// Teletype text console over a COLS x ROWS cell store (char low byte, attribute
// high byte). Commands arrive on the s_axis channel: tuser holds the opcode
// (put character, clear screen, read cell), tdata the character and the cell
// index. Each command gives exactly one result on the m_axis channel carrying
// the read cell (zero unless a read) and the cursor after the command.
// The cfg channel writes the foreground (index 0) and background (index 1)
// colours; it is always ready and should be written only while idle.
// Path per command, accept to next accept: idle and done for a put, backspace or
// newline; idle, read and done for a read; a sweep over all cells for a clear or
// for a newline or wrap on the last row, which scrolls. The store has one write and
// one read port, so scroll and clear sweep it one cell per cycle.
// The result enters the output register from the done state; a read passes the read state first.
// After reset the block fills all COLS*ROWS cells with a space in attribute
// 0x07, one per cycle, with tready low; colour writes are taken meanwhile.
// A stalled receiver holds the result in the output register; the next command
// is still accepted and worked on, and its result waits until the slot frees.
module text_console_cursor_scroll_top
    import tccs_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // char_code[7:0], cell_index[18:8], zero
    input  logic [1:0]  i_s_axis_tuser,   // opcode[1:0]
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // read_char[7:0], read_attr[15:8],
                                          // cursor_row[20:16], cursor_col[27:21], zero
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    localparam int CELLS = COLS * ROWS;
    localparam int AW    = $clog2(CELLS);

    t_cmd          cmd;
    t_res          seq_res;
    logic          seq_ready;
    logic          seq_res_valid;
    logic          s_accept;
    logic          res_load;
    logic          cfg_accept;

    logic          r_fg;
    logic [3:0]    r_fg_q, r_bg_q;
    logic          r_ov;
    t_res          r_out;
    logic [1:0]    r_item_op;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    // Input unpacking
    assign cmd.opcode     = i_s_axis_tuser;
    assign cmd.char_code  = i_s_axis_tdata[7:0];
    assign cmd.cell_index = i_s_axis_tdata[18:8];

    assign s_accept        = i_s_axis_tvalid && seq_ready;
    assign o_s_axis_tready = seq_ready;

    // Colour registers
    assign o_cfg_ready = 1'b1;
    assign cfg_accept  = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg_q <= FOREGROUND_RST;
            r_bg_q <= BACKGROUND_RST;
            r_fg   <= 1'b0;
        end else begin
            r_fg <= cfg_accept && (i_cfg_index == REG_FOREGROUND);
            if (cfg_accept && i_cfg_index == REG_FOREGROUND) begin
                r_fg_q <= i_cfg_data;
            end
            if (cfg_accept && i_cfg_index == REG_BACKGROUND) begin
                r_bg_q <= i_cfg_data;
            end
        end
    end

    // Sequencer
    tccs_seq #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (s_accept),
        .i_cmd       (cmd),
        .i_attr      ({r_bg_q, r_fg_q}),
        .o_ready     (seq_ready),
        .o_res_valid (seq_res_valid),
        .o_res       (seq_res),
        .i_res_taken (res_load),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // Cell store
    tccs_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Output register: loads when empty or being emptied in this cycle
    assign res_load = seq_res_valid && (!r_ov || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (res_load) begin
            r_ov <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= seq_res;
        end
        if (s_accept) begin
            r_item_op <= cmd.opcode;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {4'd0, r_out.cursor_col, r_out.cursor_row,
                              r_out.read_attr, r_out.read_char};

    // Checks

    // commands are taken one at a time: every accepted command closes the input
    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_axis_tready)
        else $error("command accepted on two consecutive cycles");

    // only a read returns cell contents
    a_non_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load && (r_item_op != OP_READ) |=>
            (r_out.read_char == 8'd0) && (r_out.read_attr == 8'd0))
        else $error("non-read result carries cell data");

    // a foreground write lands in the colour register
    a_fg_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fg |-> (r_fg_q == $past(i_cfg_data)))
        else $error("foreground write lost");

endmodule
